FILE: hw/rtl/symbol_list_insert_delete_defines.svh
// assertion macros for the symbol list checker
`ifndef SYMBOL_LIST_INSERT_DELETE_DEFINES_SVH
`define SYMBOL_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SLID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SLID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/slid_pkg.sv
// shared types and codes of the symbol list block
package slid_pkg;

    localparam int CNT_W = 11;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_APPEND = 2'd0;
    localparam t_mode MODE_REMOVE = 2'd1;
    localparam t_mode MODE_INSERT = 2'd2;
    localparam t_mode MODE_READ   = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_MISSING = 2'd1;
    localparam t_status ST_FULL    = 2'd2;
    localparam t_status ST_BADPOS  = 2'd3;

    typedef logic [1:0] t_op;
    localparam t_op OP_HOLD = 2'd0;
    localparam t_op OP_INS  = 2'd1;
    localparam t_op OP_SCAN = 2'd2;
    localparam t_op OP_DROP = 2'd3;

    typedef struct packed {
        t_op              op;
        logic [7:0]       sym;
        logic [CNT_W-1:0] at;
        logic [CNT_W-1:0] fill;
        logic [5:0]       ridx;
    } t_cell_ctrl;

    typedef struct packed {
        logic       gone;
        logic [7:0] data;
    } t_chain_stat;

endpackage

FILE: hw/rtl/symbol_list_insert_delete.sv
// top level of the bounded symbol list: sequencer and chain of cells
//
// input channel: i_in_valid / o_in_stall with mode, symbol, position, run_length
// and read_index; a transaction is taken when valid is high and stall is low.
// output channel: o_out_valid / i_out_stall with status, length and read_data,
// one result transaction for every input transaction, in order.
// o_in_stall is high while a request is being worked on; one request at a time.
// after acceptance the work steps run, then the output register is loaded:
//   append one tail shift, insert one tail shift per copy (run_length copies),
//   read runs the scan over all CAPACITY cells (match and read chains ripple one cell a cycle),
//   remove runs the same scan (match chain), then the gap is closed; errors do no work.
// a new request is taken while the previous result still waits in the output
// register; a finished request waits for that register to be taken.
// reset (synchronous, active low) empties the list and drops any pending result;
// cell contents are not cleared, only entries below the length are ever read.
module symbol_list_insert_delete #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_symbol,
    input  logic [6:0] i_position,
    input  logic [6:0] i_run_length,
    input  logic [5:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [6:0] o_length,
    output logic [7:0] o_read_data
);

    slid_pkg::t_cell_ctrl  w_ctrl;
    slid_pkg::t_chain_stat w_stat;

    logic [7:0] w_entry    [CAPACITY];
    logic       w_gone     [CAPACITY];
    logic [7:0] w_rd       [CAPACITY];
    logic [7:0] w_lo_entry [CAPACITY];
    logic [7:0] w_up_entry [CAPACITY];
    logic       w_lo_gone  [CAPACITY];
    logic [7:0] w_up_rd    [CAPACITY];

    slid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_symbol     (i_symbol),
        .i_position   (i_position),
        .i_run_length (i_run_length),
        .i_read_index (i_read_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_length     (o_length),
        .o_read_data  (o_read_data),
        .i_stat       (w_stat),
        .o_ctrl       (w_ctrl)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_lo_entry[g] = 8'd0;
            assign w_lo_gone[g]  = 1'b0;
        end else begin : g_mid_lo
            assign w_lo_entry[g] = w_entry[g-1];
            assign w_lo_gone[g]  = w_gone[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_up_entry[g] = 8'd0;
            assign w_up_rd[g]    = 8'd0;
        end else begin : g_mid_up
            assign w_up_entry[g] = w_entry[g+1];
            assign w_up_rd[g]    = w_rd[g+1];
        end

        slid_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_lower_entry (w_lo_entry[g]),
            .i_upper_entry (w_up_entry[g]),
            .i_lower_gone  (w_lo_gone[g]),
            .i_upper_rd    (w_up_rd[g]),
            .o_entry       (w_entry[g]),
            .o_gone        (w_gone[g]),
            .o_rd          (w_rd[g])
        );
    end

    assign w_stat.gone = w_gone[CAPACITY-1];
    assign w_stat.data = w_rd[0];

endmodule

FILE: hw/rtl/slid_cell.sv
// one list cell: entry storage, insert and remove shifts, match and read chains
module slid_cell #(
    parameter int IDX = 0
) (
    input  logic                  i_clk,
    input  slid_pkg::t_cell_ctrl  i_ctrl,
    input  logic [7:0]            i_lower_entry,
    input  logic [7:0]            i_upper_entry,
    input  logic                  i_lower_gone,
    input  logic [7:0]            i_upper_rd,
    output logic [7:0]            o_entry,
    output logic                  o_gone,
    output logic [7:0]            o_rd
);

    localparam logic [slid_pkg::CNT_W-1:0] MY_IDX = slid_pkg::CNT_W'(IDX);

    logic [7:0] r_entry;
    logic       r_gone;
    logic [7:0] r_rd;
    logic       w_hit;
    logic       w_sel;

    assign w_hit = (r_entry == i_ctrl.sym) && (MY_IDX < i_ctrl.fill);
    assign w_sel = (MY_IDX == slid_pkg::CNT_W'(i_ctrl.ridx));

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            slid_pkg::OP_INS: begin
                if (MY_IDX == i_ctrl.at) begin
                    r_entry <= i_ctrl.sym;
                end else if (MY_IDX > i_ctrl.at) begin
                    r_entry <= i_lower_entry;
                end
            end
            slid_pkg::OP_SCAN: begin
                r_gone <= i_lower_gone | w_hit;
                r_rd   <= w_sel ? r_entry : i_upper_rd;
            end
            slid_pkg::OP_DROP: begin
                if (r_gone) begin
                    r_entry <= i_upper_entry;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_entry = r_entry;
    assign o_gone  = r_gone;
    assign o_rd    = r_rd;

endmodule

FILE: hw/rtl/slid_ctrl.sv
// request sequencer, list length and result register
module slid_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_mode,
    input  logic [7:0]            i_symbol,
    input  logic [6:0]            i_position,
    input  logic [6:0]            i_run_length,
    input  logic [5:0]            i_read_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [6:0]            o_length,
    output logic [7:0]            o_read_data,
    input  slid_pkg::t_chain_stat i_stat,
    output slid_pkg::t_cell_ctrl  o_ctrl
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > 7) ? CW : 7) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DROP = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_at, n_at;
    logic [CW-1:0]       r_cnt, n_cnt;
    slid_pkg::t_status   r_status, n_status;
    logic                r_is_read, n_is_read;
    logic [7:0]          r_sym, n_sym;
    logic [5:0]          r_ridx, n_ridx;
    logic                r_out_valid, n_out_valid;
    slid_pkg::t_status   r_out_status, n_out_status;
    logic [6:0]          r_out_length, n_out_length;
    logic [7:0]          r_out_data, n_out_data;

    logic [EW-1:0] e_fill, e_pos, e_run, e_ridx, e_cap;

    assign e_fill = EW'(r_fill);
    assign e_pos  = EW'(i_position);
    assign e_run  = EW'(i_run_length);
    assign e_ridx = EW'(i_read_index);
    assign e_cap  = EW'(CAPACITY);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_at         = r_at;
        n_cnt        = r_cnt;
        n_status     = r_status;
        n_is_read    = r_is_read;
        n_sym        = r_sym;
        n_ridx       = r_ridx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_length = r_out_length;
        n_out_data   = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sym     = i_symbol;
                    n_ridx    = i_read_index;
                    n_status  = slid_pkg::ST_OK;
                    n_is_read = 1'b0;
                    n_state   = S_DONE;
                    case (i_mode)
                        slid_pkg::MODE_APPEND: begin
                            if (e_fill >= e_cap) begin
                                n_status = slid_pkg::ST_FULL;
                            end else begin
                                n_at    = r_fill;
                                n_cnt   = CW'(1);
                                n_state = S_INS;
                            end
                        end
                        slid_pkg::MODE_REMOVE: begin
                            if (r_fill == '0) begin
                                n_status = slid_pkg::ST_MISSING;
                            end else begin
                                n_cnt   = CW'(CAPACITY);
                                n_state = S_SCAN;
                            end
                        end
                        slid_pkg::MODE_INSERT: begin
                            if (e_pos == '0 || e_pos > e_fill + EW'(1)) begin
                                n_status = slid_pkg::ST_BADPOS;
                            end else if (e_fill + e_run > e_cap) begin
                                n_status = slid_pkg::ST_FULL;
                            end else if (e_run != '0) begin
                                n_at    = CW'(e_fill + EW'(1) - e_pos);
                                n_cnt   = CW'(e_run);
                                n_state = S_INS;
                            end
                        end
                        default: begin
                            n_is_read = 1'b1;
                            if (e_ridx < e_fill && e_ridx < e_cap) begin
                                n_cnt   = CW'(CAPACITY);
                                n_state = S_SCAN;
                            end else begin
                                n_status = slid_pkg::ST_BADPOS;
                            end
                        end
                    endcase
                end
            end
            S_INS: begin
                n_fill = r_fill + CW'(1);
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    if (r_is_read) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DROP;
                    end
                end
            end
            S_DROP: begin
                if (i_stat.gone) begin
                    n_fill = r_fill - CW'(1);
                end else begin
                    n_status = slid_pkg::ST_MISSING;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_length = 7'(r_fill);
                    n_out_data   = (r_is_read && r_status == slid_pkg::ST_OK)
                                   ? i_stat.data : 8'd0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_at         <= n_at;
        r_cnt        <= n_cnt;
        r_status     <= n_status;
        r_is_read    <= n_is_read;
        r_sym        <= n_sym;
        r_ridx       <= n_ridx;
        r_out_status <= n_out_status;
        r_out_length <= n_out_length;
        r_out_data   <= n_out_data;
    end

    always_comb begin
        case (r_state)
            S_INS:   o_ctrl.op = slid_pkg::OP_INS;
            S_SCAN:  o_ctrl.op = slid_pkg::OP_SCAN;
            S_DROP:  o_ctrl.op = slid_pkg::OP_DROP;
            default: o_ctrl.op = slid_pkg::OP_HOLD;
        endcase
        o_ctrl.sym  = r_sym;
        o_ctrl.at   = slid_pkg::CNT_W'(r_at);
        o_ctrl.fill = slid_pkg::CNT_W'(r_fill);
        o_ctrl.ridx = r_ridx;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_length    = r_out_length;
    assign o_read_data = r_out_data;

endmodule

FILE: hw/rtl/slid_checker.sv
// port-level checker for the symbol list, bound to the top level
`include "symbol_list_insert_delete_defines.svh"

module slid_checker #(
    parameter int CAPACITY = 64
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_status,
    input logic [6:0] o_length,
    input logic [7:0] o_read_data
);

    localparam int LEN_MAX = (CAPACITY > 127) ? 127 : CAPACITY;

    `SLID_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "no stall after accepted transaction")
    `SLID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_length) && $stable(o_read_data), "stalled result changed")
    `SLID_ASSERT_NOW(a_data_zero, i_clk, i_rst_n, o_out_valid && o_status != slid_pkg::ST_OK, o_read_data == 8'd0, "read data not zero on error")
    `SLID_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, o_out_valid && CAPACITY < 128, 32'(o_length) <= LEN_MAX, "length above capacity")

endmodule

bind symbol_list_insert_delete slid_checker #(
    .CAPACITY (CAPACITY)
) u_slid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_length    (o_length),
    .o_read_data (o_read_data)
);
